// ===== rtl/tgf_pkg.sv =====
// shared constants, tables and types of the tilt and gravity fusion filter
`timescale 1ns / 1ps

package tgf_pkg;

  // cordic vectoring steps, at most the length of the arctangent table
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int CORDIC_RUN   = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  // bit-serial multiplier: unsigned multiplier, signed multiplicand
  localparam int MUL_MP_W = 17;
  localparam int MUL_MC_W = 35;
  localparam int MUL_P_W  = 52;

  // bit-serial square root
  localparam int ROOT_RAD_W = 34;
  localparam int ROOT_W     = 17;
  localparam int ROOT_REM_W = 19;

  // gravity estimate width, counts in q.16
  localparam int GRAV_W = 34;
  // angle state width, degrees in q.16 within plus/minus 180
  localparam int ANG_W  = 25;
  // cordic datapath
  localparam int CORD_W = 36;
  localparam int ZANG_W = 26;

  // gyro increment division: rate * dt * 65536 / 131000000, rounded
  localparam int DIV_BITS = 26;
  localparam int DIV_REM_W = 28;
  localparam logic [DIV_REM_W-1:0] DIV_DEN  = 28'd131000000;
  localparam logic [MUL_P_W-1:0]   DIV_HALF = 52'd65500000;

  localparam logic signed [ZANG_W-1:0] ANG_MAX_Z = 26'sd11796480;
  localparam logic signed [ZANG_W-1:0] ANG_90_Z  = 26'sd5898240;

  // arctangent of 2^-i in q.16 degrees
  localparam logic [21:0] ATAN_TAB [ATAN_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
    22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
    22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
  };

  // configuration register map
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 20;
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_GRAVITY_KEEP  = 2'd0,
    CFG_BLEND_KEEP    = 2'd1,
    CFG_ELAPSED_LIMIT = 2'd2
  } cfg_idx_e;

  localparam logic [15:0] GRAVITY_KEEP_RST  = 16'd60293;
  localparam logic [15:0] BLEND_KEEP_RST    = 16'd64225;
  localparam logic [19:0] ELAPSED_LIMIT_RST = 20'd100000;

endpackage

// ===== rtl/tgf_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module tgf_mul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [tgf_pkg::MUL_MC_W-1:0]  mcand_i,
  input  logic        [tgf_pkg::MUL_MP_W-1:0]  mplier_i,
  output logic                                 done_o,
  output logic signed [tgf_pkg::MUL_P_W-1:0]   prod_o
);
  import tgf_pkg::*;

  logic        [MUL_MP_W-1:0] mp_q;
  logic signed [MUL_P_W-1:0]  mc_q;
  logic signed [MUL_P_W-1:0]  acc_q;

  // finished once no multiplier bits remain
  assign done_o = (mp_q == '0);
  assign prod_o = acc_q;

  // add the shifted multiplicand for each set multiplier bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mp_q  <= '0;
      mc_q  <= '0;
      acc_q <= '0;
    end else if (start_i) begin
      mp_q  <= mplier_i;
      mc_q  <= MUL_P_W'(mcand_i);
      acc_q <= '0;
    end else if (mp_q != '0) begin
      if (mp_q[0]) begin
        acc_q <= acc_q + mc_q;
      end
      mc_q <= mc_q <<< 1;
      mp_q <= mp_q >> 1;
    end
  end

endmodule

// ===== rtl/tgf_sqrt.sv =====
// bit-serial floor square root, one result bit per cycle
`timescale 1ns / 1ps

module tgf_sqrt (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [tgf_pkg::ROOT_RAD_W-1:0]     rad_i,
  output logic                               done_o,
  output logic [tgf_pkg::ROOT_W-1:0]         root_o
);
  import tgf_pkg::*;

  logic [4:0]            cnt_q;
  logic [ROOT_RAD_W-1:0] rad_q;
  logic [ROOT_REM_W-1:0] rem_q;
  logic [ROOT_W-1:0]     root_q;

  logic [ROOT_REM_W+1:0] rem_sh;
  logic [ROOT_REM_W+1:0] trial;
  logic                  fits;
  logic [ROOT_REM_W+1:0] rem_sub;

  assign done_o = (cnt_q == '0);
  assign root_o = root_q;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh  = {rem_q, rad_q[ROOT_RAD_W-1 -: 2]};
    trial   = {2'b00, root_q, 2'b01};
    fits    = (rem_sh >= trial);
    rem_sub = rem_sh - trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else if (start_i) begin
      cnt_q  <= 5'(ROOT_W);
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 5'd1;
      rad_q  <= rad_q << 2;
      rem_q  <= fits ? rem_sub[ROOT_REM_W-1:0] : rem_sh[ROOT_REM_W-1:0];
      root_q <= {root_q[ROOT_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/tilt_gravity_fusion_filter_unit.sv =====
// top level: gravity removal, magnitudes and pitch/roll complementary filter
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_ready_o   accel_x/y/z, gyro_x/y, elapsed_us
//   out      output     out_valid_o / out_ready_i motion_x/y/z, magnitudes, pitch, roll
//   cfg      input      cfg_we_i                  cfg_addr_i, cfg_wdata_i
//
// one transaction at a time. all products go through one shared bit-serial
// multiplier (one multiplier bit per cycle up to the highest set bit, so
// small operands finish sooner), roots through a bit-serial square root,
// then 16 cordic steps and a bit-serial restoring divider per angle. a
// finished result sits in the output register, so the next transaction is
// taken while it waits. asynchronous active-low reset clears all filter state.
`timescale 1ns / 1ps

module tilt_gravity_fusion_filter_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tgf_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [tgf_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [15:0]                accel_x_i,
  input  logic signed [15:0]                accel_y_i,
  input  logic signed [15:0]                accel_z_i,
  input  logic signed [15:0]                gyro_x_i,
  input  logic signed [15:0]                gyro_y_i,
  input  logic        [19:0]                elapsed_us_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [16:0]                motion_x_o,
  output logic signed [16:0]                motion_y_o,
  output logic signed [16:0]                motion_z_o,
  output logic        [16:0]                motion_magnitude_o,
  output logic        [15:0]                total_magnitude_o,
  output logic signed [16:0]                pitch_deg_o,
  output logic signed [16:0]                roll_deg_o
);
  import tgf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GMUL, ST_GWAIT, ST_SMUL, ST_SWAIT, ST_ROOT, ST_RWAIT,
    ST_CPRE, ST_CITER, ST_DMUL, ST_DWAIT, ST_DIV, ST_BMUL, ST_BWAIT, ST_OUT
  } state_e;

  // configuration registers
  logic [15:0] gravity_keep_q;
  logic [15:0] blend_keep_q;
  logic [19:0] elapsed_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_keep_q  <= GRAVITY_KEEP_RST;
      blend_keep_q    <= BLEND_KEEP_RST;
      elapsed_limit_q <= ELAPSED_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_addr_i))
        CFG_GRAVITY_KEEP:  gravity_keep_q  <= cfg_wdata_i[15:0];
        CFG_BLEND_KEEP:    blend_keep_q    <= cfg_wdata_i[15:0];
        CFG_ELAPSED_LIMIT: elapsed_limit_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  state_e state_q;
  logic [2:0] sel_q;
  logic       ang_q;
  logic [4:0] cnt_q;

  logic signed [15:0] accel_q [3];
  logic signed [15:0] gx_q, gy_q;
  logic        [19:0] dt_q;

  logic signed [GRAV_W-1:0] grav_q [3];
  logic signed [16:0]       mot_q [3];
  logic [ROOT_RAD_W-1:0]    sum_raw_q, sum_mot_q, sum_xz_q;
  logic [15:0]              total_q;
  logic [16:0]              motmag_q;
  logic [16:0]              h_q;
  logic signed [ANG_W-1:0]  pitch_q, roll_q;

  logic signed [CORD_W-1:0] cx_q, cy_q;
  logic signed [ZANG_W-1:0] cz_q;
  logic signed [ZANG_W-1:0] accang_q;
  logic [DIV_REM_W-1:0]     rem_q;
  logic [DIV_BITS-1:0]      num_q;
  logic [DIV_BITS-1:0]      quo_q;

  logic out_valid_q;
  logic signed [16:0] mx_out_q, my_out_q, mz_out_q, pitch_out_q, roll_out_q;
  logic [16:0]        motmag_out_q;
  logic [15:0]        total_out_q;

  // shared arithmetic units
  logic                       mul_start, mul_done;
  logic signed [MUL_MC_W-1:0] mul_mcand;
  logic [MUL_MP_W-1:0]        mul_mplier;
  logic signed [MUL_P_W-1:0]  mul_prod;
  logic                       sqrt_start, sqrt_done;
  logic [ROOT_RAD_W-1:0]      sqrt_rad;
  logic [ROOT_W-1:0]          sqrt_root;

  tgf_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_mcand),
    .mplier_i (mul_mplier),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  tgf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqrt_rad),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  // datapath helpers
  logic [1:0]               axis_idx;
  logic signed [GRAV_W-1:0] accel_sh;
  logic signed [GRAV_W-1:0] grav_diff;
  logic signed [MUL_P_W-1:0] g_sum;
  logic signed [GRAV_W-1:0] g_new;
  logic signed [GRAV_W-1:0] g_rnd;
  logic signed [16:0]       mot_new;
  logic signed [16:0]       sq_src;
  logic [16:0]              sq_abs;
  logic signed [15:0]       gyro_sel;
  logic [16:0]              gyro_abs;
  logic signed [ANG_W-1:0]  angle_sel;
  logic signed [DIV_BITS:0] inc;
  logic signed [27:0]       blend_diff;
  logic signed [MUL_P_W-1:0] b_sum;
  logic signed [ANG_W-1:0]  angle_new;
  logic signed [16:0]       x0, y0, x1, y1;
  logic signed [ZANG_W-1:0] z1;
  logic                     vec_zero;
  logic signed [CORD_W-1:0] xs, ys, cx_n, cy_n;
  logic signed [ZANG_W-1:0] tab_z, cz_n, cz_clamp;
  logic [MUL_P_W-1:0]       div_num;
  logic [DIV_REM_W-1:0]     rem_sh;
  logic                     div_fit;
  logic                     ang_update;
  logic signed [ZANG_W-1:0] pitch_rnd, roll_rnd;

  always_comb begin
    axis_idx = (sel_q < 3'd3) ? sel_q[1:0] : 2'(sel_q - 3'd3);

    // gravity low pass: g' = a*65536 + round(k * (g - a*65536) / 65536)
    accel_sh  = {{2{accel_q[axis_idx][15]}}, accel_q[axis_idx], 16'b0};
    grav_diff = grav_q[axis_idx] - accel_sh;
    g_sum     = MUL_P_W'(accel_sh) + ((mul_prod + 52'sd32768) >>> 16);
    g_new     = g_sum[GRAV_W-1:0];
    g_rnd     = (g_new + 34'sd32768) >>> 16;
    mot_new   = 17'({accel_q[axis_idx][15], accel_q[axis_idx]}) - g_rnd[16:0];

    // operand of the squares: raw axes first, then motion components
    sq_src = (sel_q < 3'd3) ? {accel_q[axis_idx][15], accel_q[axis_idx]} : mot_q[axis_idx];
    sq_abs = sq_src[16] ? 17'(~sq_src + 17'sd1) : 17'(sq_src);

    // angle update operands
    gyro_sel   = ang_q ? gy_q : gx_q;
    gyro_abs   = gyro_sel[15] ? 17'(-{gyro_sel[15], gyro_sel}) : {1'b0, gyro_sel};
    angle_sel  = ang_q ? roll_q : pitch_q;
    inc        = gyro_sel[15] ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    blend_diff = 28'(angle_sel) + 28'(inc) - 28'(accang_q);
    b_sum      = MUL_P_W'(accang_q) + ((mul_prod + 52'sd32768) >>> 16);
    if (b_sum > MUL_P_W'(ANG_MAX_Z)) begin
      angle_new = ANG_W'(ANG_MAX_Z);
    end else if (b_sum < -MUL_P_W'(ANG_MAX_Z)) begin
      angle_new = ANG_W'(-ANG_MAX_Z);
    end else begin
      angle_new = b_sum[ANG_W-1:0];
    end

    ang_update = (dt_q != '0) && (dt_q < elapsed_limit_q);

    // atan2 vector: pitch uses (ay, h), roll uses (-ax, az)
    if (!ang_q) begin
      y0 = {accel_q[1][15], accel_q[1]};
      x0 = $signed(h_q);
    end else begin
      y0 = -{accel_q[0][15], accel_q[0]};
      x0 = {accel_q[2][15], accel_q[2]};
    end
    vec_zero = (x0 == '0) && (y0 == '0);
    x1 = x0;
    y1 = y0;
    z1 = '0;
    // rotate into the right half plane
    if (x0[16]) begin
      if (!y0[16]) begin
        x1 = y0;
        y1 = -x0;
        z1 = ANG_90_Z;
      end else begin
        x1 = -y0;
        y1 = x0;
        z1 = -ANG_90_Z;
      end
    end

    // one cordic vectoring step
    xs    = cx_q >>> cnt_q;
    ys    = cy_q >>> cnt_q;
    tab_z = ZANG_W'(ATAN_TAB[cnt_q]);
    if (cy_q > 36'sd0) begin
      cx_n = cx_q + ys;
      cy_n = cy_q - xs;
      cz_n = cz_q + tab_z;
    end else begin
      cx_n = cx_q - ys;
      cy_n = cy_q + xs;
      cz_n = cz_q - tab_z;
    end
    if (cz_n > ANG_MAX_Z) begin
      cz_clamp = ANG_MAX_Z;
    end else if (cz_n < -ANG_MAX_Z) begin
      cz_clamp = -ANG_MAX_Z;
    end else begin
      cz_clamp = cz_n;
    end

    // rounded dividend and one restoring division step
    div_num = {mul_prod[MUL_P_W-17:0], 16'b0} + DIV_HALF;
    rem_sh  = {rem_q[DIV_REM_W-2:0], num_q[DIV_BITS-1]};
    div_fit = (rem_sh >= DIV_DEN);

    // output rounding of the angles
    pitch_rnd = (ZANG_W'(pitch_q) + 26'sd128) >>> 8;
    roll_rnd  = (ZANG_W'(roll_q) + 26'sd128) >>> 8;
  end

  // multiplier and root operand selection
  always_comb begin
    mul_start  = 1'b0;
    mul_mcand  = '0;
    mul_mplier = '0;
    sqrt_start = (state_q == ST_ROOT);
    unique case (sel_q[1:0])
      2'd0:    sqrt_rad = sum_raw_q;
      2'd1:    sqrt_rad = sum_mot_q;
      default: sqrt_rad = sum_xz_q;
    endcase
    unique case (state_q)
      ST_GMUL: begin
        mul_start  = 1'b1;
        mul_mcand  = MUL_MC_W'(grav_diff);
        mul_mplier = {1'b0, gravity_keep_q};
      end
      ST_SMUL: begin
        mul_start  = 1'b1;
        mul_mcand  = MUL_MC_W'({1'b0, sq_abs});
        mul_mplier = sq_abs;
      end
      ST_DMUL: begin
        mul_start  = 1'b1;
        mul_mcand  = MUL_MC_W'({1'b0, dt_q});
        mul_mplier = gyro_abs;
      end
      ST_BMUL: begin
        mul_start  = 1'b1;
        mul_mcand  = MUL_MC_W'(blend_diff);
        mul_mplier = {1'b0, blend_keep_q};
      end
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // sequencer with filter state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      sel_q        <= '0;
      ang_q        <= 1'b0;
      cnt_q        <= '0;
      accel_q      <= '{default: '0};
      gx_q         <= '0;
      gy_q         <= '0;
      dt_q         <= '0;
      grav_q       <= '{default: '0};
      mot_q        <= '{default: '0};
      sum_raw_q    <= '0;
      sum_mot_q    <= '0;
      sum_xz_q     <= '0;
      total_q      <= '0;
      motmag_q     <= '0;
      h_q          <= '0;
      pitch_q      <= '0;
      roll_q       <= '0;
      cx_q         <= '0;
      cy_q         <= '0;
      cz_q         <= '0;
      accang_q     <= '0;
      rem_q        <= '0;
      num_q        <= '0;
      quo_q        <= '0;
      out_valid_q  <= 1'b0;
      mx_out_q     <= '0;
      my_out_q     <= '0;
      mz_out_q     <= '0;
      motmag_out_q <= '0;
      total_out_q  <= '0;
      pitch_out_q  <= '0;
      roll_out_q   <= '0;
    end else begin
      // result taken; in the output state a new one replaces it instead
      if (out_valid_q && out_ready_i && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            accel_q   <= '{accel_x_i, accel_y_i, accel_z_i};
            gx_q      <= gyro_x_i;
            gy_q      <= gyro_y_i;
            dt_q      <= elapsed_us_i;
            sel_q     <= '0;
            ang_q     <= 1'b0;
            sum_raw_q <= '0;
            sum_mot_q <= '0;
            sum_xz_q  <= '0;
            state_q   <= ST_GMUL;
          end
        end
        ST_GMUL: state_q <= ST_GWAIT;
        ST_GWAIT: begin
          if (mul_done) begin
            grav_q[axis_idx] <= g_new;
            mot_q[axis_idx]  <= mot_new;
            if (sel_q == 3'd2) begin
              sel_q   <= '0;
              state_q <= ST_SMUL;
            end else begin
              sel_q   <= sel_q + 3'd1;
              state_q <= ST_GMUL;
            end
          end
        end
        ST_SMUL: state_q <= ST_SWAIT;
        ST_SWAIT: begin
          if (mul_done) begin
            if (sel_q < 3'd3) begin
              sum_raw_q <= sum_raw_q + mul_prod[ROOT_RAD_W-1:0];
              if (sel_q != 3'd1) begin
                sum_xz_q <= sum_xz_q + mul_prod[ROOT_RAD_W-1:0];
              end
            end else begin
              sum_mot_q <= sum_mot_q + mul_prod[ROOT_RAD_W-1:0];
            end
            if (sel_q == 3'd5) begin
              sel_q   <= '0;
              state_q <= ST_ROOT;
            end else begin
              sel_q   <= sel_q + 3'd1;
              state_q <= ST_SMUL;
            end
          end
        end
        ST_ROOT: state_q <= ST_RWAIT;
        ST_RWAIT: begin
          if (sqrt_done) begin
            priority if (sel_q == 3'd0) begin
              total_q <= sqrt_root[15:0];
              sel_q   <= 3'd1;
              state_q <= ST_ROOT;
            end else if (sel_q == 3'd1) begin
              motmag_q <= sqrt_root;
              if (ang_update) begin
                sel_q   <= 3'd2;
                state_q <= ST_ROOT;
              end else begin
                state_q <= ST_OUT;
              end
            end else begin
              h_q     <= sqrt_root;
              ang_q   <= 1'b0;
              state_q <= ST_CPRE;
            end
          end
        end
        ST_CPRE: begin
          cx_q  <= {{3{x1[16]}}, x1, 16'b0};
          cy_q  <= {{3{y1[16]}}, y1, 16'b0};
          cz_q  <= z1;
          cnt_q <= '0;
          if (vec_zero) begin
            accang_q <= '0;
            state_q  <= ST_DMUL;
          end else begin
            state_q <= ST_CITER;
          end
        end
        ST_CITER: begin
          cx_q <= cx_n;
          cy_q <= cy_n;
          cz_q <= cz_n;
          if (cnt_q == 5'(CORDIC_RUN - 1)) begin
            accang_q <= cz_clamp;
            state_q  <= ST_DMUL;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        ST_DMUL: state_q <= ST_DWAIT;
        ST_DWAIT: begin
          if (mul_done) begin
            rem_q   <= {2'b00, div_num[MUL_P_W-1:DIV_BITS]};
            num_q   <= div_num[DIV_BITS-1:0];
            quo_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q <= div_fit ? (rem_sh - DIV_DEN) : rem_sh;
          quo_q <= {quo_q[DIV_BITS-2:0], div_fit};
          num_q <= num_q << 1;
          if (cnt_q == 5'(DIV_BITS - 1)) begin
            state_q <= ST_BMUL;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        ST_BMUL: state_q <= ST_BWAIT;
        ST_BWAIT: begin
          if (mul_done) begin
            if (!ang_q) begin
              pitch_q <= angle_new;
              ang_q   <= 1'b1;
              state_q <= ST_CPRE;
            end else begin
              roll_q  <= angle_new;
              state_q <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            mx_out_q     <= mot_q[0];
            my_out_q     <= mot_q[1];
            mz_out_q     <= mot_q[2];
            motmag_out_q <= motmag_q;
            total_out_q  <= total_q;
            pitch_out_q  <= pitch_rnd[16:0];
            roll_out_q   <= roll_rnd[16:0];
            out_valid_q  <= 1'b1;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign motion_x_o         = mx_out_q;
  assign motion_y_o         = my_out_q;
  assign motion_z_o         = mz_out_q;
  assign motion_magnitude_o = motmag_out_q;
  assign total_magnitude_o  = total_out_q;
  assign pitch_deg_o        = pitch_out_q;
  assign roll_deg_o         = roll_out_q;

endmodule

// ===== rtl/tgf_checker.sv =====
// port-level checks on the fusion filter, bound to the top level
`timescale 1ns / 1ps

module tgf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [16:0] pitch_deg_o,
  input logic signed [16:0] roll_deg_o
);

  // a waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn before it was taken");

  // one transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a transaction was in progress");

  // a new result frees the input side
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("input not ready when a result was posted");

  // angles stay within plus/minus 180 degrees
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pitch_deg_o <= 17'sd46080 && pitch_deg_o >= -17'sd46080 &&
                     roll_deg_o <= 17'sd46080 && roll_deg_o >= -17'sd46080))
    else $error("angle output beyond plus/minus 180 degrees");

endmodule

bind tilt_gravity_fusion_filter_unit tgf_checker u_tgf_checker (.*);
